FILE: hw/rtl/iee_pkg.sv
// ----------------------------------------------------------------------------
// iee_pkg
// Types and constants shared by the infix expression evaluator files.
// ----------------------------------------------------------------------------
`default_nettype none

package iee_pkg;

  localparam int STACK_DEPTH_DEF = 16;
  localparam int FRAC_BITS_DEF   = 16;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  // Operator stack codes
  localparam logic [1:0] OP_PAR = 2'd0;
  localparam logic [1:0] OP_ADD = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  // Pending operator codes
  localparam logic [1:0] PEND_NONE   = 2'd0;
  localparam logic [1:0] PEND_MINUS  = 2'd1;
  localparam logic [1:0] PEND_TIMES  = 2'd2;
  localparam logic [1:0] PEND_DIVIDE = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_OVF   = 3'd1;
  localparam logic [2:0] ST_MAL   = 3'd2;
  localparam logic [2:0] ST_DIV0  = 3'd3;
  localparam logic [2:0] ST_SAT   = 3'd4;
  localparam logic [2:0] ST_PAREN = 3'd5;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] POS_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [2:0]         status;
  } out_item_t;

endpackage

`default_nettype wire

FILE: hw/rtl/iee_ram.sv
// ----------------------------------------------------------------------------
// iee_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: hw/rtl/infix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// infix_expression_evaluator
// Evaluates an infix expression of single digits, + - * / and parentheses,
// one character per transfer, in signed fixed point with two stacks.
// ----------------------------------------------------------------------------
//  channel  direction  payload                     handshake
//  in_      input      char_code[7:0], last        in_valid / in_stall
//  out_     output     value[63:0] signed, status  out_valid / out_stall
//
// Each reduction (at ')' and in the final drain) uses the shared arithmetic
// unit, whose shift-add multiply and shift-subtract divide loops work one
// bit per cycle. After the last character the remaining operators are reduced.
// Reset is synchronous. in_stall is high whenever a character is in work;
// a held result stalls the block only once the next result is ready to leave.
// ----------------------------------------------------------------------------
`default_nettype none

module infix_expression_evaluator #(
  parameter int STACK_DEPTH = iee_pkg::STACK_DEPTH_DEF,
  parameter int FRAC_BITS   = iee_pkg::FRAC_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire iee_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output iee_pkg::out_item_t      out_data
);

  import iee_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [6:0] MUL_LAST = 7'd63;
  localparam logic [6:0] DIV_LAST = 7'd127;

  typedef enum logic [20:0] {
    S_IDLE   = 21'h000001,
    S_DEC    = 21'h000002,
    S_PUSH   = 21'h000004,
    S_POPA   = 21'h000008,
    S_POPA_W = 21'h000010,
    S_CP     = 21'h000020,
    S_CP_W   = 21'h000040,
    S_CP2_W  = 21'h000080,
    S_RED    = 21'h000100,
    S_RED_OP = 21'h000200,
    S_RED_B  = 21'h000400,
    S_RED_A  = 21'h000800,
    S_ALU    = 21'h001000,
    S_MUL    = 21'h002000,
    S_DIV    = 21'h004000,
    S_RND    = 21'h008000,
    S_PUSHR  = 21'h010000,
    S_TAIL   = 21'h020000,
    S_DRAIN  = 21'h040000,
    S_FIN    = 21'h080000,
    S_OUT    = 21'h100000
  } state_t;

  typedef enum logic [1:0] {
    RET_TAIL  = 2'd0,
    RET_CLOSE = 2'd1,
    RET_DRAIN = 2'd2
  } ret_t;

  typedef struct packed {
    logic       vld;
    logic       is_val;
    logic [1:0] op;
  } act_t;

  state_t        state_r, state_nxt, ret_state;
  ret_t          ret_r, ret_nxt;
  logic [7:0]    c_r, c_nxt;
  logic          last_r, last_nxt;
  logic [1:0]    pend_r, pend_nxt;
  logic [2:0]    err_r, err_nxt;
  logic [CW-1:0] vc_r, vc_nxt, oc_r, oc_nxt, vc_dec, oc_dec, oc_dec2;
  act_t          act_r [4];
  act_t          act_nxt [4];
  logic [63:0]   pval_r, pval_nxt, a_r, a_nxt, b_r, b_nxt, mcand_r, mcand_nxt;
  logic [1:0]    aop_r, aop_nxt;
  logic          neg_r, neg_nxt;
  logic [64:0]   acc_r, acc_nxt;
  logic [127:0]  sh_r, sh_nxt;
  logic [6:0]    cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;

  logic          hard, vc_full, oc_full, is_digit;
  logic [63:0]   dval, ma, mb, sum;
  logic [64:0]   sum65, t65;
  logic          ge;
  logic [127:0]  prod, base, full;
  logic [128:0]  prod_ext;
  logic          inc, over;
  logic [63:0]   mag;

  logic          vwe, owe;
  logic [AW-1:0] op_raddr;
  logic [63:0]   vrdata;
  logic [1:0]    ordata;

  function automatic logic [2:0] flag_f(input logic [2:0] cur, input logic [2:0] code);
    logic [2:0] r;
    r = cur;
    if (code == ST_SAT) begin
      if (cur == ST_OK) r = ST_SAT;
    end else if (cur == ST_OK || cur == ST_SAT) begin
      r = code;
    end
    return r;
  endfunction

  assign hard     = (err_r != ST_OK) && (err_r != ST_SAT);
  assign vc_full  = vc_r >= CW'(STACK_DEPTH);
  assign oc_full  = oc_r >= CW'(STACK_DEPTH);
  assign vc_dec   = vc_r - CW'(1);
  assign oc_dec   = oc_r - CW'(1);
  assign oc_dec2  = oc_r - CW'(2);
  assign is_digit = (c_r >= CH_ZERO) && (c_r <= CH_NINE);
  assign dval     = {56'd0, c_r - CH_ZERO} << FRAC_BITS;
  assign ma       = a_r[63] ? (64'd0 - a_r) : a_r;
  assign mb       = b_r[63] ? (64'd0 - b_r) : b_r;
  assign sum      = a_r + b_r;
  assign op_raddr = (state_r == S_CP_W) ? oc_dec2[AW-1:0] : oc_dec[AW-1:0];

  // Shared arithmetic datapath: shift-add multiply, shift-subtract divide,
  // and one rounding adder used by both.
  assign sum65    = {1'b0, acc_r[63:0]} + (sh_r[0] ? {1'b0, mcand_r} : 65'd0);
  assign t65      = {acc_r[63:0], sh_r[127]};
  assign ge       = t65 >= {1'b0, mcand_r};
  assign prod     = {acc_r[63:0], sh_r[63:0]};
  assign prod_ext = {prod, 1'b0};
  assign base     = (aop_r == OP_MUL) ? (prod >> FRAC_BITS) : sh_r;
  assign inc      = (aop_r == OP_MUL) ? prod_ext[FRAC_BITS]
                                      : (acc_r[63:0] >= (mcand_r - acc_r[63:0]));
  assign full     = base + {127'd0, inc};
  assign over     = |full[127:64];
  assign mag      = full[63:0];

  always_comb begin
    case (ret_r)
      RET_CLOSE: ret_state = S_CP;
      RET_DRAIN: ret_state = S_DRAIN;
      default:   ret_state = S_TAIL;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    ret_nxt       = ret_r;
    c_nxt         = c_r;
    last_nxt      = last_r;
    pend_nxt      = pend_r;
    err_nxt       = err_r;
    vc_nxt        = vc_r;
    oc_nxt        = oc_r;
    act_nxt       = act_r;
    pval_nxt      = pval_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    aop_nxt       = aop_r;
    neg_nxt       = neg_r;
    mcand_nxt     = mcand_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    vwe           = 1'b0;
    owe           = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          c_nxt     = in_data.char_code;
          last_nxt  = in_data.last;
          state_nxt = S_DEC;
        end
      end

      S_DEC: begin
        for (int i = 0; i < 4; i++) act_nxt[i] = '0;
        state_nxt = S_TAIL;
        if (!hard) begin
          if (pend_r != PEND_NONE) begin
            pend_nxt = PEND_NONE;
            if (is_digit) begin
              if (pend_r == PEND_MINUS) begin
                pval_nxt   = 64'd0 - dval;
                act_nxt[0] = '{vld: 1'b1, is_val: 1'b1, op: OP_ADD};
                act_nxt[1] = '{vld: 1'b1, is_val: 1'b0, op: OP_ADD};
                state_nxt  = S_PUSH;
              end else begin
                b_nxt     = dval;
                aop_nxt   = (pend_r == PEND_TIMES) ? OP_MUL : OP_DIV;
                ret_nxt   = RET_TAIL;
                state_nxt = S_POPA;
              end
            end else if (c_r == CH_LPAR) begin
              if (pend_r == PEND_MINUS) begin
                pval_nxt   = ~64'd0 << FRAC_BITS;
                act_nxt[0] = '{vld: 1'b1, is_val: 1'b0, op: OP_ADD};
                act_nxt[1] = '{vld: 1'b1, is_val: 1'b0, op: OP_MUL};
                act_nxt[2] = '{vld: 1'b1, is_val: 1'b1, op: OP_PAR};
                act_nxt[3] = '{vld: 1'b1, is_val: 1'b0, op: OP_PAR};
              end else begin
                act_nxt[0] = '{vld: 1'b1, is_val: 1'b0,
                               op: (pend_r == PEND_TIMES) ? OP_MUL : OP_DIV};
                act_nxt[1] = '{vld: 1'b1, is_val: 1'b0, op: OP_PAR};
              end
              state_nxt = S_PUSH;
            end else begin
              err_nxt = flag_f(err_r, ST_MAL);
            end
          end else if (is_digit) begin
            pval_nxt   = dval;
            act_nxt[0] = '{vld: 1'b1, is_val: 1'b1, op: OP_PAR};
            state_nxt  = S_PUSH;
          end else begin
            case (c_r)
              CH_LPAR: begin
                act_nxt[0] = '{vld: 1'b1, is_val: 1'b0, op: OP_PAR};
                state_nxt  = S_PUSH;
              end
              CH_PLUS: begin
                act_nxt[0] = '{vld: 1'b1, is_val: 1'b0, op: OP_ADD};
                state_nxt  = S_PUSH;
              end
              CH_MINUS: pend_nxt = PEND_MINUS;
              CH_STAR:  pend_nxt = PEND_TIMES;
              CH_SLASH: pend_nxt = PEND_DIVIDE;
              CH_RPAR:  state_nxt = S_CP;
              default:  state_nxt = S_TAIL;
            endcase
          end
        end
      end

      S_PUSH: begin
        if (!hard) begin
          if (act_r[0].is_val) begin
            if (vc_full) begin
              err_nxt = flag_f(err_r, ST_OVF);
            end else begin
              vwe    = 1'b1;
              vc_nxt = vc_r + CW'(1);
            end
          end else if (oc_full) begin
            err_nxt = flag_f(err_r, ST_OVF);
          end else begin
            owe    = 1'b1;
            oc_nxt = oc_r + CW'(1);
          end
        end
        act_nxt[0] = act_r[1];
        act_nxt[1] = act_r[2];
        act_nxt[2] = act_r[3];
        act_nxt[3] = '0;
        if (!act_r[1].vld) state_nxt = S_TAIL;
      end

      S_POPA: begin
        if (vc_r == '0) err_nxt = flag_f(err_r, ST_MAL);
        else            vc_nxt  = vc_dec;
        state_nxt = S_POPA_W;
      end

      S_POPA_W: begin
        a_nxt     = vrdata;
        state_nxt = hard ? S_TAIL : S_ALU;
      end

      S_CP: begin
        if (hard) begin
          state_nxt = S_TAIL;
        end else if (oc_r == '0) begin
          err_nxt   = flag_f(err_r, ST_PAREN);
          state_nxt = S_TAIL;
        end else begin
          state_nxt = S_CP_W;
        end
      end

      S_CP_W: begin
        if (ordata == OP_PAR) begin
          oc_nxt    = oc_dec;
          // The operator under the '(' is read now in case it binds tighter.
          state_nxt = (oc_dec != '0) ? S_CP2_W : S_TAIL;
        end else begin
          ret_nxt   = RET_CLOSE;
          state_nxt = S_RED;
        end
      end

      S_CP2_W: begin
        if (ordata == OP_MUL || ordata == OP_DIV) begin
          ret_nxt   = RET_TAIL;
          state_nxt = S_RED;
        end else begin
          state_nxt = S_TAIL;
        end
      end

      S_RED: begin
        if (oc_r == '0) begin
          err_nxt   = flag_f(err_r, ST_MAL);
          state_nxt = ret_state;
        end else begin
          state_nxt = S_RED_OP;
        end
      end

      S_RED_OP: begin
        if (ordata == OP_PAR) begin
          err_nxt   = flag_f(err_r, ST_PAREN);
          state_nxt = ret_state;
        end else begin
          oc_nxt  = oc_dec;
          aop_nxt = ordata;
          if (vc_r == '0) err_nxt = flag_f(err_r, ST_MAL);
          else            vc_nxt  = vc_dec;
          state_nxt = S_RED_B;
        end
      end

      S_RED_B: begin
        b_nxt = vrdata;
        if (vc_r == '0) err_nxt = flag_f(err_r, ST_MAL);
        else            vc_nxt  = vc_dec;
        state_nxt = S_RED_A;
      end

      S_RED_A: begin
        a_nxt     = vrdata;
        state_nxt = hard ? ret_state : S_ALU;
      end

      S_ALU: begin
        neg_nxt = a_r[63] ^ b_r[63];
        cnt_nxt = '0;
        acc_nxt = '0;
        case (aop_r)
          OP_ADD: begin
            if ((a_r[63] == b_r[63]) && (sum[63] != a_r[63])) begin
              err_nxt  = flag_f(err_r, ST_SAT);
              pval_nxt = a_r[63] ? SIGN_BIT : POS_MAX;
            end else begin
              pval_nxt = sum;
            end
            state_nxt = S_PUSHR;
          end
          OP_MUL: begin
            sh_nxt    = {64'd0, mb};
            mcand_nxt = ma;
            state_nxt = S_MUL;
          end
          OP_DIV: begin
            if (mb == 64'd0) begin
              err_nxt   = flag_f(err_r, ST_DIV0);
              pval_nxt  = 64'd0;
              state_nxt = S_PUSHR;
            end else begin
              sh_nxt    = {64'd0, ma} << FRAC_BITS;
              mcand_nxt = mb;
              state_nxt = S_DIV;
            end
          end
          default: begin
            err_nxt   = flag_f(err_r, ST_PAREN);
            pval_nxt  = 64'd0;
            state_nxt = S_PUSHR;
          end
        endcase
      end

      S_MUL: begin
        acc_nxt = {1'b0, sum65[64:1]};
        sh_nxt  = {64'd0, sum65[0], sh_r[63:1]};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == MUL_LAST) state_nxt = S_RND;
      end

      S_DIV: begin
        acc_nxt = ge ? (t65 - {1'b0, mcand_r}) : t65;
        sh_nxt  = {sh_r[126:0], ge};
        cnt_nxt = cnt_r + 7'd1;
        if (cnt_r == DIV_LAST) state_nxt = S_RND;
      end

      S_RND: begin
        if (neg_r) begin
          if (over || (mag > SIGN_BIT)) begin
            err_nxt  = flag_f(err_r, ST_SAT);
            pval_nxt = SIGN_BIT;
          end else begin
            pval_nxt = 64'd0 - mag;
          end
        end else if (over || mag[63]) begin
          err_nxt  = flag_f(err_r, ST_SAT);
          pval_nxt = POS_MAX;
        end else begin
          pval_nxt = mag;
        end
        state_nxt = S_PUSHR;
      end

      S_PUSHR: begin
        if (!hard) begin
          if (vc_full) begin
            err_nxt = flag_f(err_r, ST_OVF);
          end else begin
            vwe    = 1'b1;
            vc_nxt = vc_r + CW'(1);
          end
        end
        state_nxt = ret_state;
      end

      S_TAIL: begin
        if (!last_r) begin
          state_nxt = S_IDLE;
        end else begin
          if (!hard && pend_r != PEND_NONE) err_nxt = flag_f(err_r, ST_MAL);
          state_nxt = S_DRAIN;
        end
      end

      S_DRAIN: begin
        if (hard || oc_r == '0) begin
          state_nxt = S_FIN;
        end else begin
          ret_nxt   = RET_DRAIN;
          state_nxt = S_RED;
        end
      end

      S_FIN: begin
        if (!hard && vc_r == '0) err_nxt = flag_f(err_r, ST_MAL);
        state_nxt = S_OUT;
      end

      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt       = 1'b1;
          out_data_nxt.value  = hard ? 64'sd0 : vrdata;
          out_data_nxt.status = err_r;
          vc_nxt    = '0;
          oc_nxt    = '0;
          pend_nxt  = PEND_NONE;
          err_nxt   = ST_OK;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ret_r       <= RET_TAIL;
      pend_r      <= PEND_NONE;
      err_r       <= ST_OK;
      vc_r        <= '0;
      oc_r        <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 4; i++) act_r[i] <= '0;
    end else begin
      state_r     <= state_nxt;
      ret_r       <= ret_nxt;
      pend_r      <= pend_nxt;
      err_r       <= err_nxt;
      vc_r        <= vc_nxt;
      oc_r        <= oc_nxt;
      out_valid_r <= out_valid_nxt;
      act_r       <= act_nxt;
    end
  end

  always_ff @(posedge clk) begin
    c_r        <= c_nxt;
    last_r     <= last_nxt;
    pval_r     <= pval_nxt;
    a_r        <= a_nxt;
    b_r        <= b_nxt;
    aop_r      <= aop_nxt;
    neg_r      <= neg_nxt;
    mcand_r    <= mcand_nxt;
    acc_r      <= acc_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    out_data_r <= out_data_nxt;
  end

  iee_ram #(
    .WIDTH (64),
    .DEPTH (STACK_DEPTH)
  ) u_val_ram (
    .clk   (clk),
    .we    (vwe),
    .waddr (vc_r[AW-1:0]),
    .wdata (pval_r),
    .raddr (vc_dec[AW-1:0]),
    .rdata (vrdata)
  );

  iee_ram #(
    .WIDTH (2),
    .DEPTH (STACK_DEPTH)
  ) u_op_ram (
    .clk   (clk),
    .we    (owe),
    .waddr (oc_r[AW-1:0]),
    .wdata (act_r[0].op),
    .raddr (op_raddr),
    .rdata (ordata)
  );

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: hw/rtl/iee_checker.sv
// ----------------------------------------------------------------------------
// iee_checker
// Port-level checks for the infix expression evaluator, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module iee_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire iee_pkg::in_item_t  in_data,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire iee_pkg::out_item_t out_data
);

  import iee_pkg::*;

  // Every character needs decoding, so the input side closes after a transfer.
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not stalled after a transfer");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status <= ST_PAREN))
    else $error("result status out of range");

  // A hard error always yields a zero value.
  a_hard_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK && out_data.status != ST_SAT)
      |-> (out_data.value == 64'sd0))
    else $error("non-zero value with a hard error");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind infix_expression_evaluator iee_checker u_iee_checker (.*);

`default_nettype wire

FILE: test/infix_expression_evaluator_tb.sv
// ----------------------------------------------------------------------------
// Infix expression evaluator testbench
// Sends expressions one character per transfer and predicts each result
// alongside the block. The directed expressions cover every operator and every
// error case. The random expressions are mostly well formed, with some noise
// and some broken ones. The sender idles and the receiver stalls in phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module infix_expression_evaluator_tb;
  import iee_pkg::*;

  localparam int DEPTH = STACK_DEPTH_DEF;
  localparam int FRAC  = FRAC_BITS_DEF;
  localparam int TARGET_CHARS = 950;
  localparam logic [63:0] MINUS_ONE = 64'hFFFF_FFFF_FFFF_0000;

  typedef byte unsigned text_q_t[$];

  // Shadow evaluator: tracks the stacks and predicts each result.
  class expr_scoreboard;
    logic [63:0] vals[DEPTH];
    logic [1:0]  ops[DEPTH];
    int          vcnt, ocnt;
    logic [1:0]  pend;
    logic [2:0]  err;
    out_item_t   pending_results[$];
    int          errors, checked;

    function void clear();
      vcnt = 0; ocnt = 0; pend = PEND_NONE; err = ST_OK;
    endfunction

    function bit hard();
      return err != ST_OK && err != ST_SAT;
    endfunction

    function void flag(logic [2:0] code);
      if (code == ST_SAT) begin
        if (err == ST_OK) err = ST_SAT;
      end else if (!hard()) begin
        err = code;
      end
    endfunction

    function void push_val(logic [63:0] v);
      if (hard()) return;
      if (vcnt >= DEPTH) begin
        flag(ST_OVF);
        return;
      end
      vals[vcnt] = v;
      vcnt++;
    endfunction

    function logic [63:0] pop_val();
      if (vcnt == 0) begin
        flag(ST_MAL);
        return 64'd0;
      end
      vcnt--;
      return vals[vcnt];
    endfunction

    function void push_op(logic [1:0] op);
      if (hard()) return;
      if (ocnt >= DEPTH) begin
        flag(ST_OVF);
        return;
      end
      ops[ocnt] = op;
      ocnt++;
    endfunction

    function logic [63:0] mag(logic [63:0] v);
      return v[63] ? -v : v;
    endfunction

    function logic [63:0] sign_fix(bit neg, logic [127:0] m);
      if (neg) begin
        if (m > {64'd0, SIGN_BIT}) begin
          flag(ST_SAT);
          return SIGN_BIT;
        end
        return -m[63:0];
      end
      if (m > {64'd0, POS_MAX}) begin
        flag(ST_SAT);
        return POS_MAX;
      end
      return m[63:0];
    endfunction

    function logic [63:0] arith(logic [63:0] a, logic [63:0] b, logic [1:0] op);
      logic [63:0]  s;
      logic [127:0] p, n, q, r, mb;
      case (op)
        OP_ADD: begin
          s = a + b;
          if (a[63] == b[63] && s[63] != a[63]) begin
            flag(ST_SAT);
            return a[63] ? SIGN_BIT : POS_MAX;
          end
          return s;
        end
        OP_MUL: begin
          p = {64'd0, mag(a)} * {64'd0, mag(b)};
          q = (p >> FRAC) + p[FRAC-1];
          return sign_fix(a[63] ^ b[63], q);
        end
        OP_DIV: begin
          mb = {64'd0, mag(b)};
          if (mb == 0) begin
            flag(ST_DIV0);
            return 64'd0;
          end
          n = {64'd0, mag(a)} << FRAC;
          q = n / mb;
          r = n % mb;
          // Round to nearest, ties away from zero.
          if (r >= mb - r) q++;
          return sign_fix(a[63] ^ b[63], q);
        end
        default: begin
          flag(ST_PAREN);
          return 64'd0;
        end
      endcase
    endfunction

    function void reduce();
      logic [63:0] a, b;
      logic [1:0]  op;
      if (ocnt == 0) begin
        flag(ST_MAL);
        return;
      end
      op = ops[ocnt-1];
      if (op == OP_PAR) begin
        flag(ST_PAREN);
        return;
      end
      ocnt--;
      b = pop_val();
      a = pop_val();
      if (hard()) return;
      push_val(arith(a, b, op));
    endfunction

    function void close_paren();
      while (!hard()) begin
        if (ocnt == 0) begin
          flag(ST_PAREN);
          return;
        end
        if (ops[ocnt-1] == OP_PAR) begin
          ocnt--;
          if (ocnt > 0 && (ops[ocnt-1] == OP_MUL || ops[ocnt-1] == OP_DIV)) reduce();
          return;
        end
        reduce();
      end
    endfunction

    function void note_input(in_item_t it);
      logic [7:0]  c;
      logic [1:0]  p;
      logic [63:0] dval, a;
      bit          digit, used;
      out_item_t   res;
      c = it.char_code;
      digit = c >= CH_ZERO && c <= CH_NINE;
      dval = digit ? ({56'd0, c - CH_ZERO} << FRAC) : 64'd0;
      used = 0;
      if (!hard() && pend != PEND_NONE) begin
        p = pend;
        pend = PEND_NONE;
        if (digit) begin
          used = 1;
          if (p == PEND_MINUS) begin
            push_val(-dval);
            push_op(OP_ADD);
          end else begin
            a = pop_val();
            if (!hard()) push_val(arith(a, dval, (p == PEND_TIMES) ? OP_MUL : OP_DIV));
          end
        end else if (c == CH_LPAR) begin
          if (p == PEND_MINUS) begin
            push_op(OP_ADD);
            push_op(OP_MUL);
            push_val(MINUS_ONE);
          end else begin
            push_op((p == PEND_TIMES) ? OP_MUL : OP_DIV);
          end
        end else begin
          flag(ST_MAL);
        end
      end
      if (!used && !hard()) begin
        if (digit) push_val(dval);
        else if (c == CH_LPAR) push_op(OP_PAR);
        else if (c == CH_PLUS) push_op(OP_ADD);
        else if (c == CH_MINUS) pend = PEND_MINUS;
        else if (c == CH_STAR) pend = PEND_TIMES;
        else if (c == CH_SLASH) pend = PEND_DIVIDE;
        else if (c == CH_RPAR) close_paren();
      end
      if (!it.last) return;
      if (!hard() && pend != PEND_NONE) flag(ST_MAL);
      while (!hard() && ocnt > 0) reduce();
      if (!hard() && vcnt == 0) flag(ST_MAL);
      res.value = hard() ? 64'd0 : vals[vcnt-1];
      res.status = err;
      pending_results.push_back(res);
      clear();
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_res;
      checked++;
      if (pending_results.size() == 0) begin
        $error("result with none expected: value %h status %0d", got.value, got.status);
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (got.value !== exp_res.value) begin
        $error("value: expected %h, got %h", exp_res.value, got.value);
        errors++;
      end
      if (got.status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, got.status);
        errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 0;
  out_item_t out_data;

  int idle_pct = 0;
  int stall_pct = 0;
  int chars_sent = 0;
  int exprs_sent = 0;

  expr_scoreboard sb = new();

  infix_expression_evaluator DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #2 clk = ~clk;

  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_input(in_data);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_char(byte unsigned c, bit last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid = 0;
      @(negedge clk);
    end
    in_valid = 1;
    in_data.char_code = c;
    in_data.last = last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
    @(negedge clk);
  endtask

  task automatic send_expr(text_q_t t);
    foreach (t[i]) send_char(t[i], i == t.size() - 1);
    exprs_sent++;
  endtask

  task automatic send_text(string s);
    text_q_t t;
    for (int i = 0; i < s.len(); i++) t.push_back(s[i]);
    send_expr(t);
  endtask

  function automatic void gen_expr(ref text_q_t t, input int depth);
    int terms;
    string opchars;
    opchars = "+-*/";
    terms = $urandom_range(1, 4);
    for (int i = 0; i < terms; i++) begin
      if (i > 0) t.push_back(opchars[$urandom_range(3)]);
      if (depth < 3 && $urandom_range(3) == 0) begin
        t.push_back(CH_LPAR);
        gen_expr(t, depth + 1);
        t.push_back(CH_RPAR);
      end else begin
        // Zero now and then, so that division by zero turns up.
        t.push_back(8'(CH_ZERO + $urandom_range(9)));
      end
    end
  endfunction

  initial begin
    #20_000_000;
    $display("[infix_expression_evaluator] ERROR");
    $finish;
  end

  initial begin
    text_q_t t;
    string specials;
    int phase, n;
    sb.clear();
    specials = "0123456789+-*/() ";
    repeat (2) @(negedge clk);
    rst_n = 1;
    @(negedge clk);

    send_text("0");
    send_text("9");
    send_text("1+2");
    send_text("7-3");
    send_text("2*3");
    send_text("9/2");
    send_text("(1+2)*3");
    send_text("2-(3+1)");
    send_text("2*(3+4)");
    send_text("8/(1+1)");
    send_text("5/0");
    send_text("1)");
    send_text("(1");
    send_text("2*+3");
    send_text("2* 3");
    send_text("3-");
    send_text(" ");
    send_text("+1");
    send_text("12");
    send_text("1 + 2x");
    send_text("1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1+1");
    send_text("(((((((((((((((((1");
    send_text("9*9*9*9*9*9*9*9*9*9*9*9*9*9*9*9");
    send_text("0-9*9*9*9*9*9*9*9*9*9*9*9*9*9*9*9");
    send_text("1/3*3");

    while (chars_sent < TARGET_CHARS) begin
      phase = chars_sent * 4 / TARGET_CHARS;
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 73; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 73; end
        default: begin idle_pct = 37; stall_pct = 37; end
      endcase
      t.delete();
      n = $urandom_range(99);
      if (n < 80) begin
        gen_expr(t, 0);
      end else if (n < 90) begin
        repeat ($urandom_range(1, 8)) t.push_back(8'($urandom_range(255)));
      end else begin
        gen_expr(t, 0);
        if ($urandom_range(1)) t[$urandom_range(t.size() - 1)] = specials[$urandom_range(16)];
        else t.insert($urandom_range(t.size()), 8'($urandom_range(255)));
      end
      send_expr(t);
    end

    in_valid = 0;
    idle_pct = 0;
    stall_pct = 0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    // Run on for a while so that any result with none expected is caught.
    repeat (3000) @(posedge clk);
    if (sb.pending_results.size() != 0) begin
      $error("%0d results never arrived", sb.pending_results.size());
      sb.errors++;
    end
    $display("Sent %0d expressions (%0d characters) over four idle/stall phases;",
             exprs_sent, chars_sent);
    $display("checked %0d results, %0d mismatches.", sb.checked, sb.errors);
    if (sb.errors == 0) begin
      $display("[infix_expression_evaluator] OK");
    end else begin
      $display("[infix_expression_evaluator] ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/iee_pkg.sv
hw/rtl/iee_ram.sv
hw/rtl/infix_expression_evaluator.sv
hw/rtl/iee_checker.sv
test/infix_expression_evaluator_tb.sv
